@@ hdl/servo_status_poll_supervisor_macros.svh @@
// Assertion macros shared by the servo status poll supervisor
`ifndef SERVO_STATUS_POLL_SUPERVISOR_MACROS_SVH
`define SERVO_STATUS_POLL_SUPERVISOR_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SSPV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sspv same-cycle check failed");

// next-cycle implication
`define SSPV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sspv next-cycle check failed");

`endif

@@ hdl/sspv_pkg.sv @@
// Types and constants of the servo status poll supervisor
package sspv_pkg;

    localparam int unsigned ItemDataW = 72;
    localparam int unsigned ResDataW  = 40;
    localparam int unsigned AddrW     = 5;

    typedef enum logic [2:0] {
        REG_LEFT_ID       = 3'd0,
        REG_RIGHT_ID      = 3'd1,
        REG_POLL_INTERVAL = 3'd2,
        REG_REPLY_TIMEOUT = 3'd3,
        REG_RESET_DELAY   = 3'd4,
        REG_MAX_ATTEMPTS  = 3'd5
    } reg_idx_t;

    localparam logic [7:0]  LeftIdReset       = 8'd3;
    localparam logic [7:0]  RightIdReset      = 8'd2;
    localparam logic [15:0] PollIntervalReset = 16'd250;
    localparam logic [15:0] ReplyTimeoutReset = 16'd100;
    localparam logic [15:0] ResetDelayReset   = 16'd2000;
    localparam logic [2:0]  MaxAttemptsReset  = 3'd3;

    localparam logic [7:0] StatusPktSize  = 8'd9;
    localparam logic [7:0] DetailMask     = 8'hFC;
    localparam logic [7:0] DetailFaultMsk = 8'h3C;
    localparam logic [7:0] DetailTorqueOn = 8'h40;
    localparam logic [7:0] ErrBlockMask   = 8'hE5;

    localparam logic [9:0] LeftPosUp    = 10'd497;
    localparam logic [9:0] LeftPosDown  = 10'd650;
    localparam logic [9:0] RightPosUp   = 10'd588;
    localparam logic [9:0] RightPosDown = 10'd436;
    localparam logic [7:0] PlayTimeUp   = 8'd25;
    localparam logic [7:0] PlayTimeDown = 8'd5;

    typedef struct packed {
        logic [7:0]  left_servo_id;
        logic [7:0]  right_servo_id;
        logic [15:0] poll_interval_ms;
        logic [15:0] reply_timeout_ms;
        logic [15:0] reset_delay_ms;
        logic [2:0]  max_reset_attempts;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic        pkt_ok;
        logic [7:0]  pkt_size;
        logic        pkt_is_stat;
        logic [7:0]  pkt_id;
        logic [7:0]  err_byte;
        logic [7:0]  detail_byte;
        logic        target_up;
    } item_t;

    typedef struct packed {
        logic       request_valid;
        logic [7:0] request_id;
        logic       reset_valid;
        logic       reset_servo;
        logic [9:0] reset_position;
        logic [7:0] reset_play_time;
        logic       reset_led_green;
        logic       timeout_flag;
        logic       health_changed;
        logic       comm_restored;
        logic       budget_exhausted;
        logic [2:0] reset_attempt_count;
    } res_t;

endpackage

@@ hdl/servo_status_poll_supervisor.sv @@
// Top level of the servo status poll supervisor: stream ports, input and result registers
// Takes one transaction per clock when the result side keeps up: each item is held in an
// input register, the supervisor state is updated in one pass on its way to the result
// register, from which its result drives m_tdata. Every item,
// packet or tick, yields exactly one result transaction. The sustained rate of one item per
// cycle is set by the single-pass update of the poll, health and fault state.
module servo_status_poll_supervisor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // now_ms[31:0], pkt_ok[32], pkt_size[40:33], pkt_is_stat[41], pkt_id[49:42],
    // err_byte[57:50], detail_byte[65:58], target_up[66], zero[71:67]
    input  logic [sspv_pkg::ItemDataW-1:0] s_tdata,
    // action[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // request_valid[0], request_id[8:1], reset_valid[9], reset_servo[10],
    // reset_position[20:11], reset_play_time[28:21], reset_led_green[29],
    // timeout_flag[30], health_changed[31], comm_restored[32], budget_exhausted[33],
    // reset_attempt_count[36:34], zero[39:37]
    output logic [sspv_pkg::ResDataW-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sspv_pkg::AddrW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    sspv_pkg::cfg_t  cfg;
    sspv_pkg::item_t item_reg;
    sspv_pkg::res_t  res;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic [sspv_pkg::ResDataW-1:0] out_data_reg;
    logic [sspv_pkg::ResDataW-1:0] res_packed;
    logic            advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign res_packed = {3'd0, res.reset_attempt_count, res.budget_exhausted,
                         res.comm_restored, res.health_changed, res.timeout_flag,
                         res.reset_led_green, res.reset_play_time, res.reset_position,
                         res.reset_servo, res.reset_valid, res.request_id,
                         res.request_valid};

    sspv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sspv_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.action      <= s_tuser;
            item_reg.now_ms      <= s_tdata[31:0];
            item_reg.pkt_ok      <= s_tdata[32];
            item_reg.pkt_size    <= s_tdata[40:33];
            item_reg.pkt_is_stat <= s_tdata[41];
            item_reg.pkt_id      <= s_tdata[49:42];
            item_reg.err_byte    <= s_tdata[57:50];
            item_reg.detail_byte <= s_tdata[65:58];
            item_reg.target_up   <= s_tdata[66];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= res_packed;
        end
    end

endmodule

@@ hdl/sspv_cfg.sv @@
// APB configuration registers of the servo status poll supervisor
module sspv_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sspv_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output sspv_pkg::cfg_t             cfg
);

    sspv_pkg::cfg_t     cfg_reg;
    sspv_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = sspv_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_servo_id      <= sspv_pkg::LeftIdReset;
            cfg_reg.right_servo_id     <= sspv_pkg::RightIdReset;
            cfg_reg.poll_interval_ms   <= sspv_pkg::PollIntervalReset;
            cfg_reg.reply_timeout_ms   <= sspv_pkg::ReplyTimeoutReset;
            cfg_reg.reset_delay_ms     <= sspv_pkg::ResetDelayReset;
            cfg_reg.max_reset_attempts <= sspv_pkg::MaxAttemptsReset;
        end
        else if (wr_en)
        begin
            case (idx)
                sspv_pkg::REG_LEFT_ID:       cfg_reg.left_servo_id      <= pwdata[7:0];
                sspv_pkg::REG_RIGHT_ID:      cfg_reg.right_servo_id     <= pwdata[7:0];
                sspv_pkg::REG_POLL_INTERVAL: cfg_reg.poll_interval_ms   <= pwdata[15:0];
                sspv_pkg::REG_REPLY_TIMEOUT: cfg_reg.reply_timeout_ms   <= pwdata[15:0];
                sspv_pkg::REG_RESET_DELAY:   cfg_reg.reset_delay_ms     <= pwdata[15:0];
                sspv_pkg::REG_MAX_ATTEMPTS:  cfg_reg.max_reset_attempts <= pwdata[2:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            sspv_pkg::REG_LEFT_ID:       prdata = {24'd0, cfg_reg.left_servo_id};
            sspv_pkg::REG_RIGHT_ID:      prdata = {24'd0, cfg_reg.right_servo_id};
            sspv_pkg::REG_POLL_INTERVAL: prdata = {16'd0, cfg_reg.poll_interval_ms};
            sspv_pkg::REG_REPLY_TIMEOUT: prdata = {16'd0, cfg_reg.reply_timeout_ms};
            sspv_pkg::REG_RESET_DELAY:   prdata = {16'd0, cfg_reg.reset_delay_ms};
            sspv_pkg::REG_MAX_ATTEMPTS:  prdata = {29'd0, cfg_reg.max_reset_attempts};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

@@ hdl/sspv_core.sv @@
// Poll, health, fault and reset-budget state with its single-pass update
`include "servo_status_poll_supervisor_macros.svh"

module sspv_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  sspv_pkg::item_t item,
    input  sspv_pkg::cfg_t  cfg,
    output sspv_pkg::res_t  res
);

    logic        poll_pending_reg, poll_pending_next;
    logic        poll_index_reg, poll_index_next;
    logic [31:0] last_request_time_reg, last_request_time_next;
    logic [1:0]  health_seen_reg, health_seen_next;
    logic [1:0]  health_responding_reg, health_responding_next;
    logic [7:0]  health_error_reg [2];
    logic [7:0]  health_error_next [2];
    logic [7:0]  health_detail_reg [2];
    logic [7:0]  health_detail_next [2];
    logic [1:0]  fault_waiting_reg, fault_waiting_next;
    logic [31:0] fault_start_time_reg [2];
    logic [31:0] fault_start_time_next [2];
    logic [2:0]  attempts_used_reg [2];
    logic [2:0]  attempts_used_next [2];

    logic        k;
    logic [7:0]  polled_id;
    logic        reply_match;
    logic [7:0]  det;
    logic        need;
    logic        allowed;
    logic [31:0] since_request;
    logic [31:0] since_fault;
    logic [2:0]  attempts_inc;
    logic        pending_mid;
    logic        index_mid;

    assign k             = poll_index_reg;
    assign polled_id     = poll_index_reg ? cfg.right_servo_id : cfg.left_servo_id;
    assign reply_match   = poll_pending_reg && item.pkt_ok
                           && (item.pkt_size == sspv_pkg::StatusPktSize)
                           && item.pkt_is_stat && (item.pkt_id == polled_id);
    assign det           = item.detail_byte & sspv_pkg::DetailMask;
    assign need          = (item.err_byte != 8'd0)
                           || ((det & sspv_pkg::DetailFaultMsk) != 8'd0)
                           || ((det & sspv_pkg::DetailTorqueOn) == 8'd0);
    assign allowed       = (item.err_byte & sspv_pkg::ErrBlockMask) == 8'd0;
    assign since_request = item.now_ms - last_request_time_reg;
    assign since_fault   = item.now_ms - fault_start_time_reg[k];
    assign attempts_inc  = attempts_used_reg[k] + 3'd1;

    always_comb
    begin
        poll_pending_next      = poll_pending_reg;
        poll_index_next        = poll_index_reg;
        last_request_time_next = last_request_time_reg;
        health_seen_next       = health_seen_reg;
        health_responding_next = health_responding_reg;
        health_error_next      = health_error_reg;
        health_detail_next     = health_detail_reg;
        fault_waiting_next     = fault_waiting_reg;
        fault_start_time_next  = fault_start_time_reg;
        attempts_used_next     = attempts_used_reg;
        pending_mid            = poll_pending_reg;
        index_mid              = poll_index_reg;
        res                    = '0;

        if (!item.action)
        begin
            if (reply_match)
            begin
                res.health_changed = !health_seen_reg[k] || !health_responding_reg[k]
                                     || (health_error_reg[k] != item.err_byte)
                                     || (health_detail_reg[k] != det);
                res.comm_restored  = health_seen_reg[k] && !health_responding_reg[k];
                health_seen_next[k]       = 1'b1;
                health_responding_next[k] = 1'b1;
                health_error_next[k]      = item.err_byte;
                health_detail_next[k]     = det;

                if (!need || !allowed)
                begin
                    fault_waiting_next[k] = 1'b0;
                end
                else if (!fault_waiting_reg[k])
                begin
                    fault_waiting_next[k]    = 1'b1;
                    fault_start_time_next[k] = item.now_ms;
                end
                else if ((attempts_used_reg[k] < cfg.max_reset_attempts)
                         && (since_fault >= {16'd0, cfg.reset_delay_ms}))
                begin
                    attempts_used_next[k]    = attempts_inc;
                    fault_start_time_next[k] = item.now_ms;
                    res.reset_valid          = 1'b1;
                    res.reset_servo          = k;
                    if (!k)
                    begin
                        res.reset_position = item.target_up ? sspv_pkg::LeftPosUp
                                                            : sspv_pkg::LeftPosDown;
                    end
                    else
                    begin
                        res.reset_position = item.target_up ? sspv_pkg::RightPosUp
                                                            : sspv_pkg::RightPosDown;
                    end
                    res.reset_play_time     = item.target_up ? sspv_pkg::PlayTimeUp
                                                             : sspv_pkg::PlayTimeDown;
                    res.reset_led_green     = item.target_up;
                    res.budget_exhausted    = attempts_inc == cfg.max_reset_attempts;
                    res.reset_attempt_count = attempts_inc;
                end

                poll_pending_next = 1'b0;
                poll_index_next   = !k;
            end
        end
        else
        begin
            if (poll_pending_reg && (since_request >= {16'd0, cfg.reply_timeout_ms}))
            begin
                health_seen_next[k]       = 1'b1;
                health_responding_next[k] = 1'b0;
                fault_waiting_next[k]     = 1'b0;
                pending_mid               = 1'b0;
                index_mid                 = !k;
                res.timeout_flag          = 1'b1;
            end
            poll_pending_next = pending_mid;
            poll_index_next   = index_mid;
            if (!pending_mid && (since_request >= {16'd0, cfg.poll_interval_ms}))
            begin
                res.request_valid      = 1'b1;
                res.request_id         = index_mid ? cfg.right_servo_id : cfg.left_servo_id;
                last_request_time_next = item.now_ms;
                poll_pending_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_pending_reg      <= 1'b0;
            poll_index_reg        <= 1'b0;
            last_request_time_reg <= 32'd0;
            health_seen_reg       <= 2'b00;
            health_responding_reg <= 2'b00;
            health_error_reg      <= '{8'd0, 8'd0};
            health_detail_reg     <= '{8'd0, 8'd0};
            fault_waiting_reg     <= 2'b00;
            fault_start_time_reg  <= '{32'd0, 32'd0};
            attempts_used_reg     <= '{3'd0, 3'd0};
        end
        else if (fire)
        begin
            poll_pending_reg      <= poll_pending_next;
            poll_index_reg        <= poll_index_next;
            last_request_time_reg <= last_request_time_next;
            health_seen_reg       <= health_seen_next;
            health_responding_reg <= health_responding_next;
            health_error_reg      <= health_error_next;
            health_detail_reg     <= health_detail_next;
            fault_waiting_reg     <= fault_waiting_next;
            fault_start_time_reg  <= fault_start_time_next;
            attempts_used_reg     <= attempts_used_next;
        end
    end

    `SSPV_ASSERT_NEXT(a_request_arms_poll, clk, rst_n, fire && res.request_valid, poll_pending_reg)
    `SSPV_ASSERT_NOW(a_reset_counts_attempt, clk, rst_n, res.reset_valid, res.reset_attempt_count != 3'd0)
    `SSPV_ASSERT_NOW(a_timeout_not_reply, clk, rst_n, res.timeout_flag, !res.health_changed && !res.reset_valid)

endmodule

@@ verif/tb_servo_status_poll_supervisor.sv @@
// Self-checking stream testbench for the servo status poll supervisor
module tb_servo_status_poll_supervisor;

    typedef struct {
        sspv_pkg::cfg_t regs;
        int unsigned    span;
        bit             calm;
        bit             wrap;
    } phase_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [sspv_pkg::ItemDataW-1:0] s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [sspv_pkg::ResDataW-1:0]  m_tdata;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [sspv_pkg::AddrW-1:0]     paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    sspv_pkg::cfg_t regs = {sspv_pkg::LeftIdReset, sspv_pkg::RightIdReset,
                            sspv_pkg::PollIntervalReset, sspv_pkg::ReplyTimeoutReset,
                            sspv_pkg::ResetDelayReset, sspv_pkg::MaxAttemptsReset};
    logic        awaiting_reply = 1'b0;
    logic        polled_servo = 1'b0;
    logic [31:0] last_poll_ms = '0;
    logic [1:0]  seen_reply = '0;
    logic [1:0]  talking = '0;
    logic [1:0]  fault_armed = '0;
    logic [7:0]  last_error [2] = '{8'h00, 8'h00};
    logic [7:0]  last_detail [2] = '{8'h00, 8'h00};
    logic [31:0] fault_began [2] = '{32'h0, 32'h0};
    logic [2:0]  resets_spent [2] = '{3'd0, 3'd0};

    sspv_pkg::res_t  expected_reports [$];
    sspv_pkg::item_t script_items [$];
    bit              script_typed [$];
    sspv_pkg::res_t  script_want [$];
    phase_t          plan [$];

    sspv_pkg::res_t got_report;
    sspv_pkg::res_t want_report;
    int unsigned    errors = 0;
    int unsigned    reports_seen = 0;
    logic [31:0]    t_ms = '0;
    int unsigned    span_ms = 1;
    bit             source_calm = 1'b0;
    bit             sink_calm = 1'b0;
    int unsigned    sink_hold = 0;

    servo_status_poll_supervisor u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] servo_id(input logic idx);
        return idx ? regs.right_servo_id : regs.left_servo_id;
    endfunction

    function automatic sspv_pkg::res_t supervise_item(input sspv_pkg::item_t it);
        sspv_pkg::res_t r;
        logic           k;
        logic           up;
        logic           need;
        logic           allowed;
        logic [7:0]     det;
        logic [31:0]    elapsed;
        r = '0;
        if (!it.action)
        begin
            if (awaiting_reply && it.pkt_ok && it.pkt_size == sspv_pkg::StatusPktSize
                && it.pkt_is_stat && it.pkt_id == servo_id(polled_servo))
            begin
                k = polled_servo;
                up = it.target_up;
                det = it.detail_byte & sspv_pkg::DetailMask;
                r.health_changed = !seen_reply[k] || !talking[k]
                    || last_error[k] != it.err_byte || last_detail[k] != det;
                r.comm_restored = seen_reply[k] && !talking[k];
                seen_reply[k] = 1'b1;
                talking[k] = 1'b1;
                last_error[k] = it.err_byte;
                last_detail[k] = det;
                need = it.err_byte != 8'h00 || (det & sspv_pkg::DetailFaultMsk) != 8'h00
                    || (det & sspv_pkg::DetailTorqueOn) == 8'h00;
                allowed = (it.err_byte & sspv_pkg::ErrBlockMask) == 8'h00;
                elapsed = it.now_ms - fault_began[k];
                if (!need || !allowed)
                    fault_armed[k] = 1'b0;
                else if (!fault_armed[k])
                begin
                    fault_armed[k] = 1'b1;
                    fault_began[k] = it.now_ms;
                end
                else if (resets_spent[k] < regs.max_reset_attempts
                         && elapsed >= 32'(regs.reset_delay_ms))
                begin
                    resets_spent[k] = resets_spent[k] + 3'd1;
                    fault_began[k] = it.now_ms;
                    r.reset_valid = 1'b1;
                    r.reset_servo = k;
                    if (k)
                        r.reset_position = up ? sspv_pkg::RightPosUp : sspv_pkg::RightPosDown;
                    else
                        r.reset_position = up ? sspv_pkg::LeftPosUp : sspv_pkg::LeftPosDown;
                    r.reset_play_time = up ? sspv_pkg::PlayTimeUp : sspv_pkg::PlayTimeDown;
                    r.reset_led_green = up;
                    r.budget_exhausted = resets_spent[k] == regs.max_reset_attempts;
                    r.reset_attempt_count = resets_spent[k];
                end
                awaiting_reply = 1'b0;
                polled_servo = !k;
            end
        end
        else
        begin
            elapsed = it.now_ms - last_poll_ms;
            if (awaiting_reply && elapsed >= 32'(regs.reply_timeout_ms))
            begin
                seen_reply[polled_servo] = 1'b1;
                talking[polled_servo] = 1'b0;
                fault_armed[polled_servo] = 1'b0;
                awaiting_reply = 1'b0;
                polled_servo = !polled_servo;
                r.timeout_flag = 1'b1;
            end
            if (!awaiting_reply && elapsed >= 32'(regs.poll_interval_ms))
            begin
                r.request_valid = 1'b1;
                r.request_id = servo_id(polled_servo);
                last_poll_ms = it.now_ms;
                awaiting_reply = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [sspv_pkg::ItemDataW-1:0] pack_item(input sspv_pkg::item_t it);
        return {5'b0, it.target_up, it.detail_byte, it.err_byte, it.pkt_id,
                it.pkt_is_stat, it.pkt_size, it.pkt_ok, it.now_ms};
    endfunction

    function automatic sspv_pkg::res_t unpack_report(
        input logic [sspv_pkg::ResDataW-1:0] d);
        sspv_pkg::res_t r;
        r.request_valid = d[0];
        r.request_id = d[8:1];
        r.reset_valid = d[9];
        r.reset_servo = d[10];
        r.reset_position = d[20:11];
        r.reset_play_time = d[28:21];
        r.reset_led_green = d[29];
        r.timeout_flag = d[30];
        r.health_changed = d[31];
        r.comm_restored = d[32];
        r.budget_exhausted = d[33];
        r.reset_attempt_count = d[36:34];
        return r;
    endfunction

    function automatic sspv_pkg::item_t tick_at(input logic [31:0] now);
        sspv_pkg::item_t it;
        it = '0;
        it.action = 1'b1;
        it.now_ms = now;
        return it;
    endfunction

    function automatic sspv_pkg::item_t packet_at(input logic [31:0] now, input logic ok,
                                                  input logic [7:0] size, input logic stat,
                                                  input logic [7:0] id, input logic [7:0] err,
                                                  input logic [7:0] det, input logic up);
        sspv_pkg::item_t it;
        it.action = 1'b0;
        it.now_ms = now;
        it.pkt_ok = ok;
        it.pkt_size = size;
        it.pkt_is_stat = stat;
        it.pkt_id = id;
        it.err_byte = err;
        it.detail_byte = det;
        it.target_up = up;
        return it;
    endfunction

    function automatic sspv_pkg::res_t poll_res(input logic [7:0] id);
        sspv_pkg::res_t r;
        r = '0;
        r.request_valid = 1'b1;
        r.request_id = id;
        return r;
    endfunction

    function automatic sspv_pkg::res_t flag_res(input logic tout, input logic changed,
                                                input logic restored);
        sspv_pkg::res_t r;
        r = '0;
        r.timeout_flag = tout;
        r.health_changed = changed;
        r.comm_restored = restored;
        return r;
    endfunction

    function automatic sspv_pkg::res_t reset_res(input logic changed, input logic servo,
                                                 input logic [9:0] pos,
                                                 input logic [7:0] play,
                                                 input logic led, input logic spent,
                                                 input logic [2:0] tries);
        sspv_pkg::res_t r;
        r = '0;
        r.health_changed = changed;
        r.reset_valid = 1'b1;
        r.reset_servo = servo;
        r.reset_position = pos;
        r.reset_play_time = play;
        r.reset_led_green = led;
        r.budget_exhausted = spent;
        r.reset_attempt_count = tries;
        return r;
    endfunction

    function automatic void add_row(input sspv_pkg::item_t it, input bit typed,
                                    input sspv_pkg::res_t want);
        script_items.push_back(it);
        script_typed.push_back(typed);
        script_want.push_back(want);
    endfunction

    function automatic phase_t phase_of(input logic [7:0] left, input logic [7:0] right,
                                        input logic [15:0] interval,
                                        input logic [15:0] timeout,
                                        input logic [15:0] delay, input logic [2:0] budget,
                                        input int unsigned span, input bit calm,
                                        input bit wrap);
        phase_t p;
        p.regs = {left, right, interval, timeout, delay, budget};
        p.span = span;
        p.calm = calm;
        p.wrap = wrap;
        return p;
    endfunction

    function automatic int unsigned pause_length();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic int unsigned source_gap();
        if (source_calm || $urandom_range(0, 99) < 55)
            return 0;
        return pause_length();
    endfunction

    function automatic sspv_pkg::item_t random_item();
        sspv_pkg::item_t it;
        logic [95:0]     raw;
        int unsigned     pick;
        pick = $urandom_range(0, 99);
        if (pick >= 85)
        begin
            raw = {$urandom, $urandom, $urandom};
            return raw[$bits(sspv_pkg::item_t)-1:0];
        end
        t_ms = t_ms + $urandom_range(0, span_ms);
        it.action = (pick < 45) ? !awaiting_reply : (pick < 70);
        it.now_ms = t_ms;
        it.pkt_ok = 1'b1;
        it.pkt_size = sspv_pkg::StatusPktSize;
        it.pkt_is_stat = 1'b1;
        it.pkt_id = servo_id(polled_servo);
        it.target_up = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0:
            begin
                it.err_byte = 8'h00;
                it.detail_byte = sspv_pkg::DetailTorqueOn | (8'($urandom) & 8'h83);
            end
            1:
            begin
                it.err_byte = 8'($urandom) & ~sspv_pkg::ErrBlockMask;
                it.detail_byte = 8'($urandom);
            end
            2:
            begin
                it.err_byte = last_error[polled_servo];
                it.detail_byte = last_detail[polled_servo] | 8'($urandom_range(0, 3));
            end
            3:
            begin
                it.err_byte = 8'h00;
                it.detail_byte = 8'($urandom) & ~sspv_pkg::DetailTorqueOn;
            end
            default:
            begin
                it.err_byte = 8'($urandom);
                it.detail_byte = 8'($urandom);
            end
        endcase
        if (pick >= 70)
        begin
            case ($urandom_range(0, 3))
                0: it.pkt_ok = 1'b0;
                1: it.pkt_size = sspv_pkg::StatusPktSize ^ 8'($urandom_range(1, 255));
                2: it.pkt_is_stat = 1'b0;
                default: it.pkt_id = it.pkt_id ^ 8'($urandom_range(1, 255));
            endcase
        end
        return it;
    endfunction

    function automatic void flag_report(input sspv_pkg::res_t want, input sspv_pkg::res_t got,
                                        input bit stray);
        errors++;
        if (errors <= 10)
        begin
            if (stray)
                $display("report %0d arrived with nothing expected: %p", reports_seen, got);
            else
                $display("report %0d: expected %p, got %p", reports_seen, want, got);
        end
    endfunction

    task automatic send_item(input sspv_pkg::item_t it, input bit typed,
                             input sspv_pkg::res_t want, output sspv_pkg::res_t predicted);
        int unsigned gap;
        gap = source_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_item(it);
        s_tuser <= it.action;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        predicted = supervise_item(it);
        expected_reports.push_back(typed ? want : predicted);
    endtask

    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input sspv_pkg::reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        case (idx)
            sspv_pkg::REG_LEFT_ID:       regs.left_servo_id = value[7:0];
            sspv_pkg::REG_RIGHT_ID:      regs.right_servo_id = value[7:0];
            sspv_pkg::REG_POLL_INTERVAL: regs.poll_interval_ms = value[15:0];
            sspv_pkg::REG_REPLY_TIMEOUT: regs.reply_timeout_ms = value[15:0];
            sspv_pkg::REG_RESET_DELAY:   regs.reset_delay_ms = value[15:0];
            sspv_pkg::REG_MAX_ATTEMPTS:  regs.max_reset_attempts = value[2:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input sspv_pkg::cfg_t c);
        write_reg(sspv_pkg::REG_LEFT_ID, 32'(c.left_servo_id));
        write_reg(sspv_pkg::REG_RIGHT_ID, 32'(c.right_servo_id));
        write_reg(sspv_pkg::REG_POLL_INTERVAL, 32'(c.poll_interval_ms));
        write_reg(sspv_pkg::REG_REPLY_TIMEOUT, 32'(c.reply_timeout_ms));
        write_reg(sspv_pkg::REG_RESET_DELAY, 32'(c.reset_delay_ms));
        write_reg(sspv_pkg::REG_MAX_ATTEMPTS, 32'(c.max_reset_attempts));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (sink_hold != 0)
            sink_hold--;
        else if (!sink_calm && $urandom_range(0, 99) < 25)
            sink_hold = pause_length();
        m_tready <= (sink_hold == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            reports_seen++;
            got_report = unpack_report(m_tdata);
            if (expected_reports.size() == 0)
                flag_report('0, got_report, 1'b1);
            else
            begin
                want_report = expected_reports.pop_front();
                if (got_report !== want_report)
                    flag_report(want_report, got_report, 1'b0);
            end
        end
    end

    initial
    begin : stimulus
        sspv_pkg::item_t it;
        sspv_pkg::res_t  r;
        int unsigned     sent;
        bit              held;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        add_row(packet_at(32'd0, 1'b1, sspv_pkg::StatusPktSize, 1'b1, sspv_pkg::LeftIdReset,
                          8'h00, sspv_pkg::DetailTorqueOn, 1'b0), 1'b1, '0);
        add_row(tick_at(32'd249), 1'b1, '0);
        add_row(tick_at(32'd250), 1'b1, poll_res(sspv_pkg::LeftIdReset));
        add_row(packet_at(32'd260, 1'b0, sspv_pkg::StatusPktSize, 1'b1, sspv_pkg::LeftIdReset,
                          8'h00, sspv_pkg::DetailTorqueOn, 1'b0), 1'b1, '0);
        add_row(packet_at(32'd261, 1'b1, 8'd255, 1'b1, sspv_pkg::LeftIdReset,
                          8'h00, sspv_pkg::DetailTorqueOn, 1'b0), 1'b1, '0);
        add_row(packet_at(32'd262, 1'b1, sspv_pkg::StatusPktSize, 1'b0, sspv_pkg::LeftIdReset,
                          8'h00, sspv_pkg::DetailTorqueOn, 1'b0), 1'b1, '0);
        add_row(packet_at(32'd263, 1'b1, sspv_pkg::StatusPktSize, 1'b1, 8'd255,
                          8'h00, sspv_pkg::DetailTorqueOn, 1'b0), 1'b1, '0);
        add_row(packet_at(32'd300, 1'b1, sspv_pkg::StatusPktSize, 1'b1, sspv_pkg::LeftIdReset,
                          8'h00, 8'h43, 1'b0), 1'b1, flag_res(1'b0, 1'b1, 1'b0));
        add_row(tick_at(32'd499), 1'b1, '0);
        add_row(tick_at(32'd500), 1'b1, poll_res(sspv_pkg::RightIdReset));
        add_row(tick_at(32'd599), 1'b1, '0);
        add_row(tick_at(32'd600), 1'b1, flag_res(1'b1, 1'b0, 1'b0));
        add_row(tick_at(32'd750), 1'b1, poll_res(sspv_pkg::LeftIdReset));
        add_row(packet_at(32'd760, 1'b1, sspv_pkg::StatusPktSize, 1'b1, sspv_pkg::LeftIdReset,
                          8'h02, sspv_pkg::DetailTorqueOn, 1'b0), 1'b1,
                flag_res(1'b0, 1'b1, 1'b0));
        add_row(tick_at(32'd1000), 1'b1, poll_res(sspv_pkg::RightIdReset));
        add_row(packet_at(32'd1010, 1'b1, sspv_pkg::StatusPktSize, 1'b1,
                          sspv_pkg::RightIdReset, 8'h00, 8'h00, 1'b0), 1'b1,
                flag_res(1'b0, 1'b1, 1'b1));
        add_row(tick_at(32'd1250), 1'b1, poll_res(sspv_pkg::LeftIdReset));
        add_row(packet_at(32'd2760, 1'b1, sspv_pkg::StatusPktSize, 1'b1,
                          sspv_pkg::LeftIdReset, 8'h02, sspv_pkg::DetailTorqueOn, 1'b1),
                1'b1, reset_res(1'b0, 1'b0, sspv_pkg::LeftPosUp, sspv_pkg::PlayTimeUp,
                                1'b1, 1'b0, 3'd1));
        add_row(tick_at(32'd3000), 1'b1, poll_res(sspv_pkg::RightIdReset));
        add_row(packet_at(32'd3010, 1'b1, sspv_pkg::StatusPktSize, 1'b1,
                          sspv_pkg::RightIdReset, 8'h10, sspv_pkg::DetailTorqueOn, 1'b0),
                1'b1, reset_res(1'b1, 1'b1, sspv_pkg::RightPosDown, sspv_pkg::PlayTimeDown,
                                1'b0, 1'b0, 3'd1));
        add_row(tick_at(32'd3250), 1'b1, poll_res(sspv_pkg::LeftIdReset));
        add_row(packet_at(32'd3260, 1'b1, sspv_pkg::StatusPktSize, 1'b1,
                          sspv_pkg::LeftIdReset, 8'h01, sspv_pkg::DetailTorqueOn, 1'b0),
                1'b1, flag_res(1'b0, 1'b1, 1'b0));
        add_row(tick_at(32'hFFFF_FFFF), 1'b1, poll_res(sspv_pkg::RightIdReset));
        add_row(tick_at(32'd99), 1'b1, flag_res(1'b1, 1'b0, 1'b0));
        add_row(tick_at(32'd256), 1'b1, poll_res(sspv_pkg::LeftIdReset));
        add_row(packet_at(32'd300, 1'b1, sspv_pkg::StatusPktSize, 1'b1,
                          sspv_pkg::LeftIdReset, 8'hFF, 8'hFF, 1'b1), 1'b0, '0);

        plan.push_back(phase_of(8'd0, 8'd253, 16'd1, 16'd1, 16'd0, 3'd2, 4, 1'b0, 1'b1));
        plan.push_back(phase_of(8'd253, 8'd0, 16'd20, 16'd30, 16'd50, 3'd4, 40, 1'b0, 1'b0));
        plan.push_back(phase_of(8'd17, 8'd17, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 70000,
                                1'b0, 1'b0));
        plan.push_back(phase_of(8'd255, 8'd254, 16'd0, 16'd0, 16'd1, 3'd0, 3, 1'b0, 1'b0));
        plan.push_back(phase_of(8'd5, 8'd6, 16'd10, 16'd40, 16'd100, 3'd7, 30, 1'b1, 1'b0));
        plan.push_back(phase_of(sspv_pkg::LeftIdReset, sspv_pkg::RightIdReset,
                                sspv_pkg::PollIntervalReset, sspv_pkg::ReplyTimeoutReset,
                                sspv_pkg::ResetDelayReset, sspv_pkg::MaxAttemptsReset, 600,
                                1'b0, 1'b0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_items[i])
            send_item(script_items[i], script_typed[i], script_want[i], r);
        drain_reports();

        foreach (plan[p])
        begin
            load_setting(plan[p].regs);
            span_ms = plan[p].span;
            source_calm = plan[p].calm;
            sink_calm = plan[p].calm;
            t_ms = plan[p].wrap ? 32'hFFFF_FFC0 : $urandom;
            sent = 0;
            held = 1'b0;
            while (sent < 220)
            begin
                it = random_item();
                send_item(it, 1'b0, '0, r);
                sent++;
                if (sent >= 110 && !held)
                begin
                    drain_reports();
                    held = 1'b1;
                end
            end
            drain_reports();
        end

        repeat (8) @(posedge clk);
        if (errors == 0 && expected_reports.size() == 0)
            $display("servo_status_poll_supervisor: match");
        else
            $display("servo_status_poll_supervisor: mismatch");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("servo_status_poll_supervisor: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sspv_pkg.sv
hdl/sspv_cfg.sv
hdl/sspv_core.sv
hdl/servo_status_poll_supervisor.sv
verif/tb_servo_status_poll_supervisor.sv
